>>> src/rtd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rtd_pkg
// Shared constants, request codes and controller/datapath interface types
// for the interleaved rANS table decoder.
// ---------------------------------------------------------------------------
package rtd_pkg;

  localparam int LANES         = 32;
  localparam int MIN_PROB_BITS = 9;
  localparam int MAX_PROB_BITS = 11;
  localparam int WORD_BITS     = 16;
  localparam int MIN_STATE     = 65536;

  localparam int TABLE_DEPTH = 1 << MAX_PROB_BITS;
  localparam int TBL_AW      = MAX_PROB_BITS;
  localparam int LANE_AW     = $clog2(LANES);
  localparam int STATE_W     = 32;
  localparam int SYM_W       = 8;
  localparam int PDF_W       = 12;
  localparam int OFS_SHIFT   = 20;
  localparam int SHIFT_W     = STATE_W - MIN_PROB_BITS;
  localparam int LANE_W      = 5;
  localparam int CFG_W       = 4;

  localparam logic [CFG_W-1:0] PROB_BITS_RESET = CFG_W'(10);

  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_SET    = 2'd1;
  localparam logic [1:0] REQ_DECODE = 2'd2;

  typedef struct packed {
    logic capture;
    logic set_status;
    logic lane_set;
    logic tbl_rd;
    logic fill_wr;
    logic mul;
    logic upd;
    logic out_load;
  } rtd_cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       overflow;
    logic       pdf_zero;
    logic       fill_last;
    logic       lane_ok;
    logic       out_free;
  } rtd_sts_t;

  // Clamp the configured resolution to the supported range.
  function automatic logic [CFG_W-1:0] eff_bits(input logic [CFG_W-1:0] b);
    logic [CFG_W-1:0] r;
    r = b;
    if (b < CFG_W'(MIN_PROB_BITS)) r = CFG_W'(MIN_PROB_BITS);
    if (b > CFG_W'(MAX_PROB_BITS)) r = CFG_W'(MAX_PROB_BITS);
    return r;
  endfunction

endpackage

>>> src/rtd_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rtd_ctrl
// Request sequencer: dispatches load, set and decode transactions and
// issues datapath commands step by step.
// ---------------------------------------------------------------------------
module rtd_ctrl
  import rtd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  rtd_sts_t sts,
  output rtd_cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_FILL   = 3'd2;
  localparam logic [2:0] S_MUL    = 3'd3;
  localparam logic [2:0] S_ADD    = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0] state, state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_FINISH;
        case (sts.req)
          REQ_LOAD: begin
            if (sts.overflow) begin
              cmd.set_status = 1'b1;
            end else if (!sts.pdf_zero) begin
              state_next = S_FILL;
            end
          end
          REQ_SET: begin
            cmd.lane_set = sts.lane_ok;
          end
          REQ_DECODE: begin
            if (sts.lane_ok) begin
              cmd.tbl_rd = 1'b1;
              state_next = S_MUL;
            end
          end
          default: begin
            state_next = S_FINISH;
          end
        endcase
      end
      S_FILL: begin
        cmd.fill_wr = 1'b1;
        if (sts.fill_last) state_next = S_FINISH;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.upd    = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        // hold the result until the output register frees up
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> src/rtd_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rtd_datapath
// Decode table and lane state memories, cumulative count, state update
// arithmetic and the output register.
// ---------------------------------------------------------------------------
module rtd_datapath
  import rtd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic [CFG_W-1:0]     prob_bits,
  input  logic [1:0]           req_type,
  input  logic [SYM_W-1:0]     symbol,
  input  logic [PDF_W-1:0]     symbol_prob,
  input  logic [LANE_W-1:0]    lane,
  input  logic [STATE_W-1:0]   initial_state,
  input  logic [WORD_BITS-1:0] encoded_word,
  input  rtd_cmd_t             cmd,
  output rtd_sts_t             sts,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [SYM_W-1:0]     decoded_symbol,
  output logic                 word_consumed,
  output logic                 status
);

  logic [CFG_W-1:0]     cur_prob_bits;
  logic [PDF_W-1:0]     running_cdf;
  logic [1:0]           req_q;
  logic [SYM_W-1:0]     req_sym;
  logic [PDF_W-1:0]     req_pdf;
  logic [LANE_W-1:0]    req_lane;
  logic [STATE_W-1:0]   req_init;
  logic [WORD_BITS-1:0] req_word;
  logic [TBL_AW-1:0]    fill_cnt;
  logic [STATE_W-1:0]   prod;
  logic [SYM_W-1:0]     res_sym;
  logic                 res_consumed;
  logic                 res_status;

  logic [STATE_W-1:0] decode_table [TABLE_DEPTH];
  logic [STATE_W-1:0] lane_states [LANES];
  logic [STATE_W-1:0] tbl_rd;
  logic [STATE_W-1:0] lane_rd;

  logic [CFG_W-1:0]         eff;
  logic [TBL_AW-1:0]        tbl_mask;
  logic [PDF_W:0]           tbl_size;
  logic [PDF_W:0]           load_sum;
  logic [TBL_AW-1:0]        fill_addr;
  logic [STATE_W-1:0]       fill_data;
  logic                     fill_last;
  logic [TBL_AW-1:0]        tbl_raddr;
  logic [SHIFT_W-1:0]       st_shifted;
  logic [PDF_W-1:0]         ent_pdf;
  logic [PDF_W-1:0]         ent_ofs;
  logic [PDF_W+SHIFT_W-1:0] prod_full;
  logic [STATE_W-1:0]       upd_sum;
  logic [STATE_W-1:0]       renorm;
  logic                     need_word;
  logic [STATE_W-1:0]       new_state;
  logic                     lane_we;
  logic [STATE_W-1:0]       lane_wd;
  logic                     out_free;

  assign eff       = eff_bits(cur_prob_bits);
  assign tbl_mask  = TBL_AW'((32'd1 << eff) - 32'd1);
  assign tbl_size  = (PDF_W+1)'(32'd1 << eff);
  assign load_sum  = {1'b0, running_cdf} + {1'b0, req_pdf};
  assign fill_addr = TBL_AW'(running_cdf + PDF_W'(fill_cnt));
  assign fill_data = {PDF_W'(fill_cnt), req_pdf, req_sym};
  assign fill_last = ({1'b0, fill_cnt} + PDF_W'(1)) == req_pdf;
  assign tbl_raddr = lane_rd[TBL_AW-1:0] & tbl_mask;

  // state update: pdf * (state >> bits) + offset, then renormalize
  assign st_shifted = SHIFT_W'(lane_rd >> eff);
  assign ent_pdf    = tbl_rd[OFS_SHIFT-1:SYM_W];
  assign ent_ofs    = tbl_rd[STATE_W-1:OFS_SHIFT];
  assign prod_full  = ent_pdf * st_shifted;
  assign upd_sum    = prod + STATE_W'(ent_ofs);
  assign need_word  = upd_sum < STATE_W'(MIN_STATE);
  assign renorm     = (upd_sum << WORD_BITS) | STATE_W'(req_word);
  assign new_state  = need_word ? renorm : upd_sum;

  assign lane_we = cmd.lane_set | cmd.upd;
  assign lane_wd = cmd.lane_set ? req_init : new_state;

  assign out_free = !out_valid || out_ready;

  assign sts.req       = req_q;
  assign sts.overflow  = load_sum > tbl_size;
  assign sts.pdf_zero  = (req_pdf == '0);
  assign sts.fill_last = fill_last;
  assign sts.lane_ok   = (32'(req_lane) < LANES);
  assign sts.out_free  = out_free;

  always_ff @(posedge clk) begin
    if (cmd.fill_wr) begin
      decode_table[fill_addr] <= fill_data;
    end
    if (cmd.tbl_rd) begin
      tbl_rd <= decode_table[tbl_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (lane_we) begin
      lane_states[LANE_AW'(req_lane)] <= lane_wd;
    end
    if (cmd.capture) begin
      lane_rd <= lane_states[LANE_AW'(lane)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_prob_bits <= PROB_BITS_RESET;
      running_cdf   <= '0;
    end else if (cfg_valid) begin
      // a new resolution starts a new table
      cur_prob_bits <= prob_bits;
      running_cdf   <= '0;
    end else if (cmd.fill_wr && fill_last) begin
      running_cdf <= PDF_W'(load_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q    <= req_type;
      req_sym  <= symbol;
      req_pdf  <= symbol_prob;
      req_lane <= lane;
      req_init <= initial_state;
      req_word <= encoded_word;
    end
    if (cmd.mul) begin
      prod <= prod_full[STATE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      fill_cnt <= '0;
    end else if (cmd.fill_wr) begin
      fill_cnt <= fill_cnt + TBL_AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      res_sym      <= '0;
      res_consumed <= 1'b0;
      res_status   <= 1'b0;
    end else begin
      if (cmd.set_status) res_status <= 1'b1;
      if (cmd.upd) begin
        res_sym      <= tbl_rd[SYM_W-1:0];
        res_consumed <= need_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      decoded_symbol <= res_sym;
      word_consumed  <= res_consumed;
      status         <= res_status;
    end
  end

endmodule

>>> src/rans_table_decoder.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rans_table_decoder
// Table-driven rANS decoder with interleaved 32-bit lane states: loads
// build the symbol table, sets seed a lane, decodes emit one symbol.
// ---------------------------------------------------------------------------
//  channel  signals                                    dir  role
//  cfg      cfg_valid, cfg_ready, prob_bits            in   table resolution
//  in       in_valid, in_ready, req_type, symbol,      in   one request
//           symbol_prob, lane, initial_state,
//           encoded_word
//  out      out_valid, out_ready, decoded_symbol,      out  one result
//           word_consumed, status
//
// One request at a time. Decode steps through lane read, table read,
// multiply, add and renormalize, and result load; set and rejected
// loads skip to result load; a load writes symbol_prob slots, one per cycle.
// Reset is synchronous; memories have no reset and are defined once written.
// A stalled output holds the finished result; the next request is taken as
// soon as the result moves into the output register.
// ---------------------------------------------------------------------------
module rans_table_decoder
  import rtd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_W-1:0]     prob_bits,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           req_type,
  input  logic [SYM_W-1:0]     symbol,
  input  logic [PDF_W-1:0]     symbol_prob,
  input  logic [LANE_W-1:0]    lane,
  input  logic [STATE_W-1:0]   initial_state,
  input  logic [WORD_BITS-1:0] encoded_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [SYM_W-1:0]     decoded_symbol,
  output logic                 word_consumed,
  output logic                 status
);

  rtd_cmd_t cmd;
  rtd_sts_t sts;

  assign cfg_ready = 1'b1;

  rtd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rtd_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .prob_bits      (prob_bits),
    .req_type       (req_type),
    .symbol         (symbol),
    .symbol_prob    (symbol_prob),
    .lane           (lane),
    .initial_state  (initial_state),
    .encoded_word   (encoded_word),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .decoded_symbol (decoded_symbol),
    .word_consumed  (word_consumed),
    .status         (status)
  );

  // one transaction in flight at a time
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in progress");

  // never overwrite an undelivered result
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free)
    else $error("output register overwritten");

  // table lookup only for a lane that exists
  a_lane_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.tbl_rd |-> sts.lane_ok && sts.req == REQ_DECODE)
    else $error("table read for invalid lane or request");

  // a rejected load reports nothing else
  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> decoded_symbol == '0 && !word_consumed)
    else $error("overflow status with decode fields set");

endmodule
